// ----- rtl/core/request_throttle_with_backoff_macros.svh -----
// Assertion macros shared by the request throttle RTL.
`ifndef REQUEST_THROTTLE_WITH_BACKOFF_MACROS_SVH
`define REQUEST_THROTTLE_WITH_BACKOFF_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of clock, off during reset.
`define RTB_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rtb: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge of clock, off during reset.
`define RTB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rtb: next-cycle check failed");

`endif

// ----- rtl/core/rtb_pkg.sv -----
// Types and constants shared by the request throttle modules.
package rtb_pkg;

   localparam int INTERVAL_W = 16;
   localparam int TIMER_W    = 24;
   localparam int FACTOR_W   = 8;
   localparam int ID_PORT_W  = 8;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;

   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd1000;
   localparam logic [INTERVAL_W-1:0] SINCE_MAX      = 16'hFFFF;
   localparam logic [FACTOR_W-1:0]   BACKOFF_MAX    = 8'd255;
   localparam logic [FACTOR_W-1:0]   BACKOFF_STEP   = 8'd2;

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_CANCEL  = 2'd2,
      OP_BACKOFF = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_NONE      = 3'd0,
      ST_GRANTED   = 3'd1,
      ST_QUEUED    = 3'd2,
      ST_REJECTED  = 3'd3,
      ST_CANCELLED = 3'd4,
      ST_NOT_FOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_SHIFT,
      S_FIN
   } state_type;

   // Commands from the sequencer to the timer unit.
   typedef struct packed {
      logic tick;
      logic clear_since;
      logic arm_prep;
      logic arm_from_since;
      logic arm_load;
      logic backoff;
   } tmr_cmd_type;

   // Status from the timer unit to the sequencer.
   typedef struct packed {
      logic elapsed;
      logic fire_due;
   } tmr_stat_type;

endpackage

// ----- rtl/core/request_throttle_with_backoff.sv -----
// Top level of the request throttle: sequencer, wait queue RAM and timer unit.
//
// The block lets requests through at most once per interval_ticks ticks. Each item
// is a tick, a request, a cancel or a backoff, taken when start is high and busy is
// low; exactly one result comes back per item, shown for a single cycle with
// rsp_strobe high, and the receiver cannot hold it off. For a tick, request or
// backoff the item passes through S_EXEC and S_FIN, and its result strobes in the
// cycle in which the next item may already be taken. A cancel walks the wait
// queue held in a RAM, one entry per cycle through the RAM's single read port,
// visiting at most QUEUE_DEPTH entries. The interval register is written through
// the csr_ channel, which is ready only while no item is in progress. Waiting ids
// live in a circular buffer in the RAM; entries are never cleared, and only
// entries that were written are read.
`include "request_throttle_with_backoff_macros.svh"

module request_throttle_with_backoff #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Item input.
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_op,
   input  logic [rtb_pkg::ID_PORT_W-1:0]        req_requester_id,
   // Results.
   output logic                                 rsp_strobe,
   output logic [rtb_pkg::STATUS_W-1:0]         rsp_status,
   output logic [rtb_pkg::ID_PORT_W-1:0]        rsp_grant_id,
   output logic [rtb_pkg::COUNT_W-1:0]          rsp_waiting_count,
   // Configuration.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rtb_pkg::INTERVAL_W-1:0]       csr_interval_ticks
);

   // Ids are cut to the narrower of the port width and ID_BITS.
   localparam int ID_W   = (ID_BITS < rtb_pkg::ID_PORT_W) ? ID_BITS : rtb_pkg::ID_PORT_W;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_W  = ((FILL_W > PTR_W) ? FILL_W : PTR_W) + 1;

   rtb_pkg::state_type  state_ff, state_in;
   rtb_pkg::op_type     op_ff, op_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [PTR_W-1:0]    head_ff, head_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   pos_ff, pos_in;
   rtb_pkg::status_type status_ff, status_in;
   logic [ID_W-1:0]     grant_ff, grant_in;
   logic                pop_ff, pop_in;
   logic                arm_ff, arm_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   rtb_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [rtb_pkg::ID_PORT_W-1:0] rsp_grant_ff, rsp_grant_in;
   logic [rtb_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                ram_we, ram_re;
   logic [PTR_W-1:0]    ram_waddr, ram_raddr;
   logic [ID_W-1:0]     ram_wdata, ram_rdata;

   rtb_pkg::tmr_cmd_type  tmr_cmd;
   rtb_pkg::tmr_stat_type tmr_stat;

   logic [FILL_W-1:0]   pos_next;
   logic                pos_last;

   // Physical RAM address of queue position pos, wrapping around the buffer.
   function automatic logic [PTR_W-1:0] queue_addr(input logic [PTR_W-1:0]  head,
                                                    input logic [FILL_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(head) + SUM_W'(pos);
      if (sum >= SUM_W'(QUEUE_DEPTH)) begin
         sum = sum - SUM_W'(QUEUE_DEPTH);
      end
      return sum[PTR_W-1:0];
   endfunction

   assign pos_next = pos_ff + FILL_W'(1);
   assign pos_last = (pos_next == fill_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      grant_in      = grant_ff;
      pop_in        = pop_ff;
      arm_in        = arm_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_count_in  = rsp_count_ff;
      ram_we        = 1'b0;
      ram_waddr     = queue_addr(head_ff, fill_ff);
      ram_wdata     = id_ff;
      ram_re        = 1'b0;
      ram_raddr     = head_ff;
      tmr_cmd       = '0;

      unique case (state_ff)
         rtb_pkg::S_IDLE: begin
            if (start) begin
               op_in    = rtb_pkg::op_type'(req_op);
               id_in    = req_requester_id[ID_W-1:0];
               state_in = rtb_pkg::S_EXEC;
            end
         end

         rtb_pkg::S_EXEC: begin
            status_in = rtb_pkg::ST_NONE;
            grant_in  = '0;
            pop_in    = 1'b0;
            arm_in    = 1'b0;
            state_in  = rtb_pkg::S_FIN;
            unique case (op_ff)
               rtb_pkg::OP_TICK: begin
                  tmr_cmd.tick = 1'b1;
                  if (tmr_stat.fire_due) begin
                     // More than the head waits: re-arm for a full interval.
                     if (fill_ff > FILL_W'(1)) begin
                        tmr_cmd.arm_prep = 1'b1;
                        arm_in           = 1'b1;
                     end
                     // Grant the head; its id arrives from the RAM next cycle.
                     if (fill_ff != '0) begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        head_in   = queue_addr(head_ff, FILL_W'(1));
                        fill_in   = fill_ff - FILL_W'(1);
                        pop_in    = 1'b1;
                        status_in = rtb_pkg::ST_GRANTED;
                     end
                  end
               end

               rtb_pkg::OP_REQUEST: begin
                  if (tmr_stat.elapsed && (fill_ff == '0)) begin
                     tmr_cmd.clear_since = 1'b1;
                     status_in           = rtb_pkg::ST_GRANTED;
                     grant_in            = id_ff;
                  end else if (fill_ff == FILL_W'(QUEUE_DEPTH)) begin
                     status_in = rtb_pkg::ST_REJECTED;
                  end else begin
                     // First waiter arms the timer for the rest of the interval.
                     if (fill_ff == '0) begin
                        tmr_cmd.arm_prep       = 1'b1;
                        tmr_cmd.arm_from_since = 1'b1;
                        arm_in                 = 1'b1;
                     end
                     ram_we    = 1'b1;
                     ram_waddr = queue_addr(head_ff, fill_ff);
                     ram_wdata = id_ff;
                     fill_in   = fill_ff + FILL_W'(1);
                     status_in = rtb_pkg::ST_QUEUED;
                  end
               end

               rtb_pkg::OP_CANCEL: begin
                  status_in = rtb_pkg::ST_NOT_FOUND;
                  if (fill_ff != '0) begin
                     ram_re    = 1'b1;
                     ram_raddr = head_ff;
                     pos_in    = '0;
                     state_in  = rtb_pkg::S_SCAN;
                  end
               end

               rtb_pkg::OP_BACKOFF: begin
                  tmr_cmd.backoff = 1'b1;
               end
            endcase
         end

         // The RAM shows the entry at pos_ff; the read of the next one is issued
         // ahead so a match can start compacting without a bubble.
         rtb_pkg::S_SCAN: begin
            if (!pos_last) begin
               ram_re    = 1'b1;
               ram_raddr = queue_addr(head_ff, pos_next);
            end
            if (ram_rdata == id_ff) begin
               status_in = rtb_pkg::ST_CANCELLED;
               if (pos_last) begin
                  fill_in  = fill_ff - FILL_W'(1);
                  state_in = rtb_pkg::S_FIN;
               end else begin
                  pos_in   = pos_next;
                  state_in = rtb_pkg::S_SHIFT;
               end
            end else if (pos_last) begin
               state_in = rtb_pkg::S_FIN;
            end else begin
               pos_in = pos_next;
            end
         end

         // Each entry behind the removed one moves one place toward the head.
         // The write goes to pos_ff - 1 while the read fetches pos_ff + 1, so the
         // two never touch the same entry.
         rtb_pkg::S_SHIFT: begin
            ram_we    = 1'b1;
            ram_waddr = queue_addr(head_ff, pos_ff - FILL_W'(1));
            ram_wdata = ram_rdata;
            if (pos_last) begin
               fill_in  = fill_ff - FILL_W'(1);
               state_in = rtb_pkg::S_FIN;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = queue_addr(head_ff, pos_next);
               pos_in    = pos_next;
            end
         end

         rtb_pkg::S_FIN: begin
            tmr_cmd.arm_load = arm_ff;
            rsp_strobe_in    = 1'b1;
            rsp_status_in    = status_ff;
            rsp_grant_in     = pop_ff ? rtb_pkg::ID_PORT_W'(ram_rdata)
                                      : rtb_pkg::ID_PORT_W'(grant_ff);
            rsp_count_in     = rtb_pkg::COUNT_W'(fill_ff);
            state_in         = rtb_pkg::S_IDLE;
         end

         default: begin
            state_in = rtb_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rtb_pkg::S_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      op_ff         <= op_in;
      id_ff         <= id_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      grant_ff      <= grant_in;
      pop_ff        <= pop_in;
      arm_ff        <= arm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_count_ff  <= rsp_count_in;
   end

   rtb_ram #(
      .WIDTH (ID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   rtb_timer u_timer (
      .clock    (clock),
      .reset    (reset),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_interval_ticks),
      .cmd      (tmr_cmd),
      .stat     (tmr_stat)
   );

   assign busy              = (state_ff != rtb_pkg::S_IDLE);
   assign csr_ready         = (state_ff == rtb_pkg::S_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_grant_id      = rsp_grant_ff;
   assign rsp_waiting_count = rsp_count_ff;

   `RTB_ASSERT_IMP(a_fill_bounded, 1'b1, fill_ff <= FILL_W'(QUEUE_DEPTH))
   `RTB_ASSERT_IMP(a_strobe_idle, rsp_strobe_ff, state_ff == rtb_pkg::S_IDLE)
   `RTB_ASSERT_IMP(a_walk_nonempty, (state_ff == rtb_pkg::S_SCAN) || (state_ff == rtb_pkg::S_SHIFT), fill_ff != '0)
   `RTB_ASSERT_IMP(a_queued_counts, rsp_strobe_ff && (rsp_status_ff == rtb_pkg::ST_QUEUED), fill_ff != '0)

endmodule

// ----- rtl/core/rtb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rtb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/rtb_timer.sv -----
// Interval register, elapsed counter, one-shot timer and backoff factor.
`include "request_throttle_with_backoff_macros.svh"

module rtb_timer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rtb_pkg::INTERVAL_W-1:0]  csr_data,
   input  rtb_pkg::tmr_cmd_type            cmd,
   output rtb_pkg::tmr_stat_type           stat
);

   logic [rtb_pkg::INTERVAL_W-1:0] interval_ff, interval_in;
   logic [rtb_pkg::INTERVAL_W-1:0] since_ff, since_in;
   logic [rtb_pkg::TIMER_W-1:0]    left_ff, left_in;
   logic                           armed_ff, armed_in;
   logic [rtb_pkg::FACTOR_W-1:0]   factor_ff, factor_in;
   logic [rtb_pkg::INTERVAL_W-1:0] timeout_ff, timeout_in;

   logic                           elapsed;
   logic                           fire_due;
   logic [rtb_pkg::FACTOR_W:0]     factor_sum;
   logic [rtb_pkg::TIMER_W:0]      product;

   assign elapsed  = (since_ff >= interval_ff);
   assign fire_due = armed_ff && (left_ff <= rtb_pkg::TIMER_W'(1));

   always_comb begin
      interval_in = interval_ff;
      since_in    = since_ff;
      left_in     = left_ff;
      armed_in    = armed_ff;
      factor_in   = factor_ff;
      timeout_in  = timeout_ff;
      factor_sum  = {1'b0, factor_ff} + {1'b0, rtb_pkg::BACKOFF_STEP};
      product     = (rtb_pkg::TIMER_W + 1)'(timeout_ff)
                    * (rtb_pkg::TIMER_W + 1)'({1'b0, factor_ff} + 9'd1);

      if (csr_we) begin
         interval_in = csr_data;
      end

      if (cmd.tick) begin
         if (since_ff != rtb_pkg::SINCE_MAX) begin
            since_in = since_ff + 16'd1;
         end
         if (armed_ff) begin
            if (fire_due) begin
               armed_in = 1'b0;
               left_in  = '0;
               since_in = '0;
            end else begin
               left_in = left_ff - 24'd1;
            end
         end
      end

      if (cmd.clear_since) begin
         since_in = '0;
      end

      // First half of arming: settle the factor and the base timeout.
      if (cmd.arm_prep) begin
         if (factor_ff != '0) begin
            factor_in = factor_ff - 8'd1;
         end
         if (!cmd.arm_from_since) begin
            timeout_in = interval_ff;
         end else if (elapsed) begin
            timeout_in = '0;
         end else begin
            timeout_in = interval_ff - since_ff;
         end
      end

      // Second half: scale by the already updated factor and start the timer.
      if (cmd.arm_load) begin
         left_in  = product[rtb_pkg::TIMER_W-1:0];
         armed_in = 1'b1;
      end

      if (cmd.backoff) begin
         if (factor_sum > {1'b0, rtb_pkg::BACKOFF_MAX}) begin
            factor_in = rtb_pkg::BACKOFF_MAX;
         end else begin
            factor_in = factor_sum[rtb_pkg::FACTOR_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= rtb_pkg::INTERVAL_RESET;
         since_ff    <= '0;
         left_ff     <= '0;
         armed_ff    <= 1'b0;
         factor_ff   <= '0;
      end else begin
         interval_ff <= interval_in;
         since_ff    <= since_in;
         left_ff     <= left_in;
         armed_ff    <= armed_in;
         factor_ff   <= factor_in;
      end
      timeout_ff <= timeout_in;
   end

   assign stat.elapsed  = elapsed;
   assign stat.fire_due = fire_due;

   `RTB_ASSERT_NEXT(a_fire_disarms, cmd.tick && fire_due, !armed_ff)
   `RTB_ASSERT_NEXT(a_backoff_raises, cmd.backoff, factor_ff != '0)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the request throttle: directed table and random episodes.
module tb_top;

   // The wait queue depth the block is built with; the predictor uses the same bound.
   localparam int QDEPTH = 16;
   // Generous ceiling for the whole run, far above the slowest legal schedule.
   localparam longint RUN_LIMIT = 64'd60_000_000;

   // One result item as the block reports it.
   typedef struct packed {
      rtb_pkg::status_type status;
      logic [7:0]          grant;
      logic [4:0]          waiting;
   } rsp_type;

   // One row of the directed table: either a register write or an item to send.
   // Rows with known_rsp set carry a hand-derived result; others go to the predictor.
   typedef struct packed {
      bit                  is_cfg;
      logic [15:0]         cfg_value;
      rtb_pkg::op_type     op;
      logic [7:0]          id;
      bit                  known_rsp;
      rsp_type             rsp;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_op = 2'd0;
   logic [7:0]  req_requester_id = 8'd0;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_grant_id;
   logic [4:0]  rsp_waiting_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_interval_ticks = 16'd0;

   request_throttle_with_backoff #(
      .QUEUE_DEPTH (QDEPTH),
      .ID_BITS     (8)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_requester_id   (req_requester_id),
      .rsp_strobe         (rsp_strobe),
      .rsp_status         (rsp_status),
      .rsp_grant_id       (rsp_grant_id),
      .rsp_waiting_count  (rsp_waiting_count),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_interval_ticks (csr_interval_ticks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the throttle: configuration and every piece of state.
   logic [15:0] shadow_interval;
   logic [15:0] shadow_since;
   logic [7:0]  shadow_waiters[$];
   logic [23:0] shadow_timer;
   bit          shadow_armed;
   logic [7:0]  shadow_factor;

   // Results still owed by the block, oldest first.
   rsp_type     owed_results[$];
   rsp_type     oldest;

   bit          sender_idles = 1'b1;
   int unsigned n_items;
   int unsigned n_results;
   int unsigned n_grants;
   int unsigned n_rejects;
   int unsigned n_cancel_hits;
   int unsigned n_errors;

   row_type     steps[0:25];

   // Arming the one-shot timer: the backoff factor is spent first (one step per arm),
   // then the clamped timeout is stretched by factor + 1 and folded into 24 bits.
   function automatic void arm_backoff_timer(int timeout);
      int unsigned clamped;
      if (shadow_factor != 8'd0)
         shadow_factor = shadow_factor - 8'd1;
      clamped = (timeout > 0) ? timeout : 0;
      shadow_timer = 24'(clamped * (int'(shadow_factor) + 1));
      shadow_armed = 1'b1;
   endfunction

   // Apply one item to the shadow state and return the result it produces.
   function automatic rsp_type throttle_step(rtb_pkg::op_type op, logic [7:0] id);
      rsp_type r;
      bit      hit;
      int      hit_at;
      r.status = rtb_pkg::ST_NONE;
      r.grant  = 8'd0;
      hit      = 1'b0;
      hit_at   = 0;
      case (op)
         rtb_pkg::OP_TICK: begin
            if (shadow_since != rtb_pkg::SINCE_MAX)
               shadow_since = shadow_since + 16'd1;
            if (shadow_armed) begin
               if (shadow_timer <= 24'd1) begin
                  // Expiry: restart the interval, re-arm only if someone stays behind
                  // after the head leaves, then hand the head its grant.
                  shadow_armed = 1'b0;
                  shadow_timer = 24'd0;
                  shadow_since = 16'd0;
                  if (shadow_waiters.size() > 1)
                     arm_backoff_timer(int'(shadow_interval));
                  if (shadow_waiters.size() > 0) begin
                     r.grant  = shadow_waiters.pop_front();
                     r.status = rtb_pkg::ST_GRANTED;
                  end
               end else begin
                  shadow_timer = shadow_timer - 24'd1;
               end
            end
         end
         rtb_pkg::OP_REQUEST: begin
            if (shadow_since >= shadow_interval && shadow_waiters.size() == 0) begin
               shadow_since = 16'd0;
               r.status     = rtb_pkg::ST_GRANTED;
               r.grant      = id;
            end else if (shadow_waiters.size() >= QDEPTH) begin
               r.status = rtb_pkg::ST_REJECTED;
            end else begin
               if (shadow_waiters.size() == 0)
                  arm_backoff_timer(int'(shadow_interval) - int'(shadow_since));
               shadow_waiters.push_back(id);
               r.status = rtb_pkg::ST_QUEUED;
            end
         end
         rtb_pkg::OP_CANCEL: begin
            for (int i = 0; i < shadow_waiters.size(); i++) begin
               if (!hit && shadow_waiters[i] == id) begin
                  hit    = 1'b1;
                  hit_at = i;
               end
            end
            if (hit) begin
               shadow_waiters.delete(hit_at);
               r.status = rtb_pkg::ST_CANCELLED;
            end else begin
               r.status = rtb_pkg::ST_NOT_FOUND;
            end
         end
         default: begin
            shadow_factor =
               (shadow_factor > rtb_pkg::BACKOFF_MAX - rtb_pkg::BACKOFF_STEP) ?
               rtb_pkg::BACKOFF_MAX : shadow_factor + rtb_pkg::BACKOFF_STEP;
         end
      endcase
      r.waiting = 5'(shadow_waiters.size());
      return r;
   endfunction

   // Requester ids are drawn mostly from a small pool so that cancels find their
   // target and duplicate ids sit in the queue; the rest span the whole id field.
   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 7) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, 7));
   endfunction

   // Send one item. The caller is always just past a rising edge. Random idle cycles
   // drop start first; otherwise start stays high straight into the next item.
   // An item is taken at the first edge where start is high and busy was low.
   task automatic issue(rtb_pkg::op_type op, logic [7:0] id, bit known_rsp = 1'b0,
                        rsp_type known = '0);
      rsp_type predicted;
      while (sender_idles && $urandom_range(0, 99) < 8) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start            <= 1'b1;
      req_op           <= op;
      req_requester_id <= id;
      do @(posedge clock); while (busy);
      n_items++;
      predicted = throttle_step(op, id);
      owed_results.push_back(known_rsp ? known : predicted);
   endtask

   // Hold off the sender until the block has delivered every owed result.
   // At least one edge passes so that start never gets two updates in one step.
   task automatic wait_results_drained();
      start <= 1'b0;
      do @(posedge clock); while (owed_results.size() != 0);
   endtask

   // The interval register is only written while the block is idle.
   task automatic write_interval(logic [15:0] value);
      wait_results_drained();
      csr_valid          <= 1'b1;
      csr_interval_ticks <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid       <= 1'b0;
      shadow_interval = value;
   endtask

   // Keep ticking until the queue has emptied through timer expiry, with a cap.
   task automatic tick_until_empty(int unsigned cap);
      int unsigned n;
      n = 0;
      while (shadow_waiters.size() != 0 && n < cap) begin
         issue(rtb_pkg::OP_TICK, 8'($urandom_range(0, 255)));
         n++;
      end
   endtask

   // Random traffic in episodes: a burst of requests (sometimes long enough to hit
   // the full queue), then a mixed tail that is mostly ticks and cancels, a few
   // backoffs and some fully random items, now and then followed by a drain.
   task automatic run_random_phase(int unsigned target);
      int unsigned first_item;
      int unsigned burst;
      int unsigned tail;
      int unsigned roll;
      first_item = n_items;
      while (n_items - first_item < target) begin
         if ($urandom_range(0, 24) == 0)
            wait_results_drained();
         burst = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 19) :
                                                $urandom_range(1, 5);
         repeat (burst) issue(rtb_pkg::OP_REQUEST, pick_id());
         tail = $urandom_range(3, 20);
         repeat (tail) begin
            roll = $urandom_range(0, 99);
            if (roll < 55)
               issue(rtb_pkg::OP_TICK, pick_id());
            else if (roll < 75)
               issue(rtb_pkg::OP_CANCEL, pick_id());
            else if (roll < 87)
               issue(rtb_pkg::OP_REQUEST, pick_id());
            else if (roll < 91)
               issue(rtb_pkg::OP_BACKOFF, pick_id());
            else
               issue(rtb_pkg::op_type'(2'($urandom_range(0, 3))),
                     8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 2) == 0)
            tick_until_empty(200);
      end
   endtask

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      n_errors++;
      if (n_errors <= 30)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
   endtask

   // Result checker. Outputs are sampled at the edge that ends the strobe cycle,
   // so the values seen here are the ones the block presented during that cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         n_results++;
         if (owed_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 30)
               $display("%0t: result with nothing owed, expected none, actual %0d/%0d/%0d",
                        $time, rsp_status, rsp_grant_id, rsp_waiting_count);
         end else begin
            oldest = owed_results.pop_front();
            if (rsp_status !== oldest.status)
               report_mismatch("status", oldest.status, rsp_status);
            if (rsp_grant_id !== oldest.grant)
               report_mismatch("grant_id", oldest.grant, rsp_grant_id);
            if (rsp_waiting_count !== oldest.waiting)
               report_mismatch("waiting_count", oldest.waiting, rsp_waiting_count);
            if (oldest.status == rtb_pkg::ST_GRANTED)
               n_grants++;
            if (oldest.status == rtb_pkg::ST_REJECTED)
               n_rejects++;
            if (oldest.status == rtb_pkg::ST_CANCELLED)
               n_cancel_hits++;
         end
      end
   end

   initial begin
      int unsigned guard;

      shadow_interval = rtb_pkg::INTERVAL_RESET;
      shadow_since    = 16'd0;
      shadow_timer    = 24'd0;
      shadow_armed    = 1'b0;
      shadow_factor   = 8'd0;

      // Directed table. The opening rows run on the reset interval of 1000 and check
      // the reset state, the extreme ids, both cancel outcomes and the backoff step.
      // Interval zero then grants every request at once. With a short interval the
      // timer path follows: arming from the remaining time, re-arming on expiry while
      // more entries wait, and expiry after every waiter was cancelled.
      steps = '{
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b1,
           '{rtb_pkg::ST_NONE,      8'h00, 5'd0}},
         '{1'b0, 16'd0, rtb_pkg::OP_BACKOFF, 8'h00, 1'b1,
           '{rtb_pkg::ST_NONE,      8'h00, 5'd0}},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'hFF, 1'b1,
           '{rtb_pkg::ST_QUEUED,    8'h00, 5'd1}},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h00, 1'b1,
           '{rtb_pkg::ST_QUEUED,    8'h00, 5'd2}},
         '{1'b0, 16'd0, rtb_pkg::OP_CANCEL,  8'hAA, 1'b1,
           '{rtb_pkg::ST_NOT_FOUND, 8'h00, 5'd2}},
         '{1'b0, 16'd0, rtb_pkg::OP_CANCEL,  8'hFF, 1'b1,
           '{rtb_pkg::ST_CANCELLED, 8'h00, 5'd1}},
         '{1'b0, 16'd0, rtb_pkg::OP_CANCEL,  8'h00, 1'b1,
           '{rtb_pkg::ST_CANCELLED, 8'h00, 5'd0}},
         '{1'b1, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h81, 1'b1,
           '{rtb_pkg::ST_GRANTED,   8'h81, 5'd0}},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h7E, 1'b1,
           '{rtb_pkg::ST_GRANTED,   8'h7E, 5'd0}},
         '{1'b1, 16'd3, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h5A, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h11, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h22, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'hA5, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_REQUEST, 8'h33, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_CANCEL,  8'h33, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_TICK,    8'h00, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_BACKOFF, 8'hFF, 1'b0, '0},
         '{1'b0, 16'd0, rtb_pkg::OP_BACKOFF, 8'h00, 1'b0, '0}
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (steps[r]) begin
         if (steps[r].is_cfg)
            write_interval(steps[r].cfg_value);
         else
            issue(steps[r].op, steps[r].id, steps[r].known_rsp, steps[r].rsp);
      end

      // Largest interval: a request that finds the counter far short of it queues
      // and arms the longest interval scaled by the current factor, and is then
      // cancelled again.
      write_interval(16'hFFFF);
      issue(rtb_pkg::OP_REQUEST, 8'h01);
      issue(rtb_pkg::OP_CANCEL, 8'h01);

      // Random phases over several intervals; the third runs with no sender idling.
      write_interval(16'd1);
      run_random_phase(32);
      write_interval(16'($urandom_range(2, 6)));
      run_random_phase(32);
      sender_idles = 1'b0;
      write_interval(16'd1);
      run_random_phase(32);
      sender_idles = 1'b1;
      // Switching to zero with entries still queued makes every re-arm a zero
      // timeout, which must expire on the very next tick.
      write_interval(16'd0);
      run_random_phase(32);
      write_interval(16'($urandom_range(3, 10)));
      run_random_phase(32);

      // Drive the backoff factor into saturation. The next timer is stretched to
      // hundreds of ticks, so a handful of ticks must pass without any grant before
      // the waiters are cancelled again.
      write_interval(16'd1);
      tick_until_empty(200);
      repeat (130) issue(rtb_pkg::OP_BACKOFF, pick_id());
      issue(rtb_pkg::OP_REQUEST, 8'hC3);
      issue(rtb_pkg::OP_REQUEST, 8'h3C);
      issue(rtb_pkg::OP_REQUEST, 8'h99);
      repeat (8) issue(rtb_pkg::OP_TICK, pick_id());
      issue(rtb_pkg::OP_CANCEL, 8'h3C);
      issue(rtb_pkg::OP_CANCEL, 8'h99);
      issue(rtb_pkg::OP_CANCEL, 8'hC3);

      // Wind down: wait for what is still owed, then watch for stray results.
      start <= 1'b0;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (owed_results.size() != 0 && guard < 5000);
      repeat (QDEPTH + 8) @(posedge clock);
      if (owed_results.size() != 0) begin
         n_errors++;
         $display("%0t: results never delivered, expected %0d more, actual 0",
                  $time, owed_results.size());
      end

      $display("Run covered %0d items and %0d results over several interval settings:",
               n_items, n_results);
      $display("  %0d grants, %0d full-queue rejections, %0d cancels that hit, %0d errors",
               n_grants, n_rejects, n_cancel_hits, n_errors);
      if (n_errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("Timeout: simulation ran past its limit with %0d results owed",
               owed_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rtb_pkg.sv
rtl/core/rtb_ram.sv
rtl/core/rtb_timer.sv
rtl/core/request_throttle_with_backoff.sv
tb/tb_top.sv
